@@ rtl/core/quaternion_to_rotation_matrix_defines.svh @@
// Assertion macros shared by the quaternion to rotation matrix RTL.
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH

`ifndef SYNTH
// Checked only out of reset
`define Q2R_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included
`define Q2R_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define Q2R_ASSERT(lbl, prop, msg)
`define Q2R_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/q2r_pkg.sv @@
// Shared types and constants for the quaternion to rotation matrix block.
package q2r_pkg;

  // Matrix entry count
  localparam int NUM_ENTRIES = 9;
  // Sizes of the intermediate values
  localparam int SQ_W  = 31;   // one square, at most 2^30
  localparam int NRM_W = 33;   // sum of four squares, at most 2^32
  localparam int NUM_W = 34;   // signed numerator, magnitude at most 2^32

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               degenerate;
  } out_t;

endpackage

@@ rtl/core/quaternion_to_rotation_matrix.sv @@
// Quaternion to normalised 3x3 rotation matrix, fully pipelined.
//
// Input transaction: in_data carries one quaternion (x, y, z, w), any common
// scale. Output transaction: out_data carries the nine matrix entries in
// signed Q1.OUT_FRAC_BITS plus the degenerate flag.
// The pipeline has one product stage, one sum stage, one magnitude stage,
// OUT_FRAC_BITS + 2 restoring division stages (one quotient bit per stage in
// each of nine dividers) and one rounding and saturation stage.
// Throughput is one transaction per cycle while out_stall is low; the per-bit
// divider chain sets the latency, not the rate.
// Each stage carries its own valid bit and only holds while it is full and
// the stage after it holds, so bubbles collapse and a stalled output still
// lets new input fill the empty stages. in_stall rises only once the whole
// pipeline is full and out_stall is high.
// A zero quaternion gives the identity matrix and sets degenerate.
// Synchronous reset clears all valid bits; nothing is in flight afterwards.
`include "quaternion_to_rotation_matrix_defines.svh"

module quaternion_to_rotation_matrix #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  q2r_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output q2r_pkg::out_t out_data
);
  import q2r_pkg::*;

  localparam int DS  = OUT_FRAC_BITS + 2;  // division stages, one bit each
  localparam int QW  = OUT_FRAC_BITS + 2;  // raw quotient width
  localparam int RW  = NRM_W + 1;          // trial remainder width
  localparam int SA  = 0;
  localparam int SB  = 1;
  localparam int SC  = 2;
  localparam int SD0 = 3;
  localparam int SE  = SD0 + DS;
  localparam int NS  = SE + 1;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << OUT_FRAC_BITS;
  localparam int DIAG_ONE = (OUT_FRAC_BITS >= 15) ? 32767 : (1 << OUT_FRAC_BITS);

  // Stage valid bits and advance enables
  logic [NS-1:0] v_r;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[SE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage A: squares and cross products
  logic [SQ_W-1:0]    xx_r, yy_r, zz_r, ww_r;
  logic signed [31:0] xy_r, zw_r, xz_r, yw_r, yz_r, xw_r;
  logic signed [31:0] xe, ye, ze, we;

  assign xe = 32'(in_data.quat_x);
  assign ye = 32'(in_data.quat_y);
  assign ze = 32'(in_data.quat_z);
  assign we = 32'(in_data.quat_w);

  always_ff @(posedge clk) begin
    if (en[SA]) begin
      xx_r <= SQ_W'(xe * xe);
      yy_r <= SQ_W'(ye * ye);
      zz_r <= SQ_W'(ze * ze);
      ww_r <= SQ_W'(we * we);
      xy_r <= xe * ye;
      zw_r <= ze * we;
      xz_r <= xe * ze;
      yw_r <= ye * we;
      yz_r <= ye * ze;
      xw_r <= xe * we;
    end
  end

  // Stage B: norm and the nine numerators
  logic [NRM_W-1:0]        nb_r;
  logic signed [NUM_W-1:0] numb_r [NUM_ENTRIES];
  logic signed [NUM_W-1:0] numb_nxt [NUM_ENTRIES];
  logic signed [NUM_W-1:0] sxx, syy, szz, sww;

  assign sxx = signed'(NUM_W'(xx_r));
  assign syy = signed'(NUM_W'(yy_r));
  assign szz = signed'(NUM_W'(zz_r));
  assign sww = signed'(NUM_W'(ww_r));

  always_comb begin
    numb_nxt[0] = sxx + sww - syy - szz;
    numb_nxt[1] = (NUM_W'(xy_r) - NUM_W'(zw_r)) <<< 1;
    numb_nxt[2] = (NUM_W'(xz_r) + NUM_W'(yw_r)) <<< 1;
    numb_nxt[3] = (NUM_W'(xy_r) + NUM_W'(zw_r)) <<< 1;
    numb_nxt[4] = syy + sww - sxx - szz;
    numb_nxt[5] = (NUM_W'(yz_r) - NUM_W'(xw_r)) <<< 1;
    numb_nxt[6] = (NUM_W'(xz_r) - NUM_W'(yw_r)) <<< 1;
    numb_nxt[7] = (NUM_W'(yz_r) + NUM_W'(xw_r)) <<< 1;
    numb_nxt[8] = szz + sww - sxx - syy;
  end

  always_ff @(posedge clk) begin
    if (en[SB]) begin
      nb_r   <= NRM_W'(xx_r) + NRM_W'(yy_r) + NRM_W'(zz_r) + NRM_W'(ww_r);
      numb_r <= numb_nxt;
    end
  end

  // Stage C: sign and magnitude, zero-norm detect
  logic [NRM_W-1:0] nc_r;
  logic             degc_r;
  logic             negc_r [NUM_ENTRIES];
  logic [NRM_W-1:0] magc_r [NUM_ENTRIES];

  always_ff @(posedge clk) begin
    if (en[SC]) begin
      nc_r   <= nb_r;
      degc_r <= (nb_r == '0);
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        negc_r[e] <= numb_r[e][NUM_W-1];
        magc_r[e] <= numb_r[e][NUM_W-1] ? NRM_W'(-numb_r[e]) : NRM_W'(numb_r[e]);
      end
    end
  end

  // Division stages: one restoring step per stage for each entry
  logic [NRM_W-1:0] div_n_r   [DS];
  logic             div_deg_r [DS];
  logic             div_neg_r [DS][NUM_ENTRIES];
  logic [NRM_W-1:0] div_rem_r [DS][NUM_ENTRIES];
  logic [QW-1:0]    div_q_r   [DS][NUM_ENTRIES];

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [NRM_W-1:0] n_in;
    logic             deg_in;
    logic             neg_in [NUM_ENTRIES];
    logic [RW-1:0]    r_in   [NUM_ENTRIES];
    logic [QW-1:0]    q_in   [NUM_ENTRIES];
    logic [NRM_W-1:0] rem_nxt [NUM_ENTRIES];
    logic [QW-1:0]    q_nxt   [NUM_ENTRIES];

    if (j == 0) begin : g_first
      always_comb begin
        n_in   = nc_r;
        deg_in = degc_r;
        for (int e = 0; e < NUM_ENTRIES; e++) begin
          neg_in[e] = negc_r[e];
          r_in[e]   = RW'(magc_r[e]);
          q_in[e]   = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        n_in   = div_n_r[j-1];
        deg_in = div_deg_r[j-1];
        for (int e = 0; e < NUM_ENTRIES; e++) begin
          neg_in[e] = div_neg_r[j-1][e];
          r_in[e]   = {div_rem_r[j-1][e], 1'b0};
          q_in[e]   = div_q_r[j-1][e];
        end
      end
    end

    // Trial subtract against the norm
    always_comb begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        if (r_in[e] >= RW'(n_in)) begin
          rem_nxt[e] = NRM_W'(r_in[e] - RW'(n_in));
          q_nxt[e]   = {q_in[e][QW-2:0], 1'b1};
        end else begin
          rem_nxt[e] = NRM_W'(r_in[e]);
          q_nxt[e]   = {q_in[e][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[SD0+j]) begin
        div_n_r[j]   <= n_in;
        div_deg_r[j] <= deg_in;
        div_neg_r[j] <= neg_in;
        div_rem_r[j] <= rem_nxt;
        div_q_r[j]   <= q_nxt;
      end
    end
  end

  // Stage E: round half away, saturate, identity on zero norm
  logic signed [15:0] ent_nxt [NUM_ENTRIES];

  always_comb begin
    logic [QW:0]        rnd;
    logic [QW-1:0]      qc;
    logic signed [31:0] sv;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      rnd = (QW+1)'(div_q_r[DS-1][e]) + (QW+1)'(1);
      qc  = rnd[QW:1];
      if (qc > ONE_Q) begin
        qc = ONE_Q;
      end
      sv = div_neg_r[DS-1][e] ? -signed'(32'(qc)) : signed'(32'(qc));
      if (sv > 32767) begin
        sv = 32767;
      end else if (sv < -32768) begin
        sv = -32768;
      end
      if (div_deg_r[DS-1]) begin
        sv = (e == 0 || e == 4 || e == 8) ? DIAG_ONE : 0;
      end
      ent_nxt[e] = 16'(sv);
    end
  end

  always_ff @(posedge clk) begin
    if (en[SE]) begin
      out_data.m00        <= ent_nxt[0];
      out_data.m01        <= ent_nxt[1];
      out_data.m02        <= ent_nxt[2];
      out_data.m10        <= ent_nxt[3];
      out_data.m11        <= ent_nxt[4];
      out_data.m12        <= ent_nxt[5];
      out_data.m20        <= ent_nxt[6];
      out_data.m21        <= ent_nxt[7];
      out_data.m22        <= ent_nxt[8];
      out_data.degenerate <= div_deg_r[DS-1];
    end
  end

  // Partial identity pattern on the output register (m00, m01 and m22 only)
  logic out_ident;

  assign out_ident = (out_data.m00 == 16'(DIAG_ONE)) && (out_data.m01 == '0) &&
                     (out_data.m22 == 16'(DIAG_ONE));

  // Checks
  `Q2R_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "valid out of reset")
  `Q2R_ASSERT(a_stall_full, in_stall |-> (&v_r) && out_stall, "input held with room left")
  `Q2R_ASSERT(a_degen_identity, out_valid && out_data.degenerate |-> out_ident, "not identity")
  `Q2R_ASSERT(a_flow, v_r[SE-1] && !v_r[SE] |=> out_valid, "item lost before output")

endmodule
